// ===== hdl/pixel_replication_upscaler_assert.svh =====
// assertion macros for the upscaler modules, included by pru_ctrl
`ifndef PIXEL_REPLICATION_UPSCALER_ASSERT_SVH
`define PIXEL_REPLICATION_UPSCALER_ASSERT_SVH

// cond in a cycle requires expr in the same cycle
`define PRU_ASSERT_IMPL(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("pixel replication upscaler check failed");

// cond in a cycle requires expr in the next cycle
`define PRU_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("pixel replication upscaler check failed");

`endif

// ===== hdl/pru_pkg.sv =====
// types and constants of the pixel replication upscaler
`timescale 1ns / 1ps

package pru_pkg;

   localparam int SCALE_W = 7;
   localparam int WIDTH_W = 11;
   localparam int CSR_W   = 11;
   localparam int PIX_W   = 24;
   localparam int USER_W  = 4;

   localparam logic [SCALE_W-1:0] SCALE_RESET = 7'd1;
   localparam logic [WIDTH_W-1:0] WIDTH_RESET = 11'd1;

   typedef enum logic {
      CMD_PUSH = 1'b0,
      CMD_PULL = 1'b1
   } cmd_type;

   typedef enum logic [2:0] {
      ST_PUSHED  = 3'd0,
      ST_REFUSED = 3'd1,
      ST_PIXEL   = 3'd2,
      ST_PAD     = 3'd3,
      ST_EMPTY   = 3'd4
   } status_type;

   typedef enum logic {
      CSR_SCALE = 1'b0,
      CSR_WIDTH = 1'b1
   } csr_index_type;

   typedef struct packed {
      status_type status;
      logic       line_end;
      logic       row_done;
   } result_type;

endpackage

// ===== hdl/pru_line_store.sv =====
// line store: one write port, one registered read port
`timescale 1ns / 1ps

module pru_line_store #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [AW-1:0]             wr_addr,
   input  logic [pru_pkg::PIX_W-1:0] wr_data,
   input  logic                      rd_en,
   input  logic [AW-1:0]             rd_addr,
   output logic [pru_pkg::PIX_W-1:0] rd_data
);

   logic [pru_pkg::PIX_W-1:0] mem [DEPTH];
   logic [pru_pkg::PIX_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // holds its value until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/pru_ctrl.sv =====
// load and replay sequencer: counters, config registers, store addressing
`timescale 1ns / 1ps
`include "pixel_replication_upscaler_assert.svh"

module pru_ctrl #(
   parameter int MAX_WIDTH = 1024,
   parameter int MAX_SCALE = 100,
   parameter int CW        = 11,
   parameter int AW        = 10
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic [0:0]                  csr_index,
   input  logic [pru_pkg::CSR_W-1:0]   csr_wdata,
   input  logic                        accept,
   input  pru_pkg::cmd_type            cmd,
   output logic                        mem_we,
   output logic [AW-1:0]               mem_waddr,
   output logic                        mem_re,
   output logic [AW-1:0]               mem_raddr,
   output pru_pkg::result_type         result
);

   logic [pru_pkg::SCALE_W-1:0] scale_ff, scale_in;
   logic [pru_pkg::WIDTH_W-1:0] width_ff, width_in;

   logic [CW-1:0]               stored_ff, stored_in;
   logic [CW-1:0]               rpos_ff, rpos_in;
   logic [pru_pkg::SCALE_W-1:0] rep_ff, rep_in;
   logic [pru_pkg::SCALE_W-1:0] replica_ff, replica_in;
   logic [1:0]                  pad_cnt_ff, pad_cnt_in;
   logic                        replaying_ff, replaying_in;

   logic [CW-1:0]               w_eff;
   logic [pru_pkg::SCALE_W-1:0] s_eff;
   logic [3:0]                  low_prod;
   logic [1:0]                  line_mod;
   logic [1:0]                  pad_len;
   logic [pru_pkg::SCALE_W:0]   rep_sum;
   logic [pru_pkg::SCALE_W:0]   replica_sum;
   logic [2:0]                  pad_sum;
   logic [CW-1:0]               rpos_next;
   logic                        le;

   // register writes
   always_comb begin
      scale_in = scale_ff;
      width_in = width_ff;
      if (csr_we) begin
         unique case (pru_pkg::csr_index_type'(csr_index))
            pru_pkg::CSR_SCALE: scale_in = csr_wdata[pru_pkg::SCALE_W-1:0];
            pru_pkg::CSR_WIDTH: width_in = csr_wdata[pru_pkg::WIDTH_W-1:0];
            default: ;
         endcase
      end
   end

   // clamp live registers to the supported range
   always_comb begin
      priority if (width_ff == '0) begin
         w_eff = CW'(1);
      end else if (int'(width_ff) > MAX_WIDTH) begin
         w_eff = CW'(MAX_WIDTH);
      end else begin
         w_eff = CW'(width_ff);
      end
      priority if (scale_ff == '0) begin
         s_eff = pru_pkg::SCALE_W'(1);
      end else if (int'(scale_ff) > MAX_SCALE) begin
         s_eff = pru_pkg::SCALE_W'(MAX_SCALE);
      end else begin
         s_eff = scale_ff;
      end
   end

   // pad bytes to a 4-byte line: only the low two bits of width and scale matter
   assign low_prod = {2'b00, w_eff[1:0]} * {2'b00, s_eff[1:0]};
   assign line_mod = 2'(low_prod * 4'd3);
   assign pad_len  = 2'd0 - line_mod;

   always_comb begin
      stored_in    = stored_ff;
      rpos_in      = rpos_ff;
      rep_in       = rep_ff;
      replica_in   = replica_ff;
      pad_cnt_in   = pad_cnt_ff;
      replaying_in = replaying_ff;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      rep_sum      = {1'b0, rep_ff} + 1'b1;
      replica_sum  = {1'b0, replica_ff} + 1'b1;
      pad_sum      = {1'b0, pad_cnt_ff} + 3'd1;
      rpos_next    = rpos_ff;
      le           = 1'b0;
      result       = '{status: pru_pkg::ST_EMPTY, line_end: 1'b0, row_done: 1'b0};
      if (accept) begin
         if (cmd == pru_pkg::CMD_PUSH) begin
            priority if (replaying_ff) begin
               result.status = pru_pkg::ST_REFUSED;
            end else if (stored_ff >= w_eff) begin
               replaying_in  = 1'b1;
               result.status = pru_pkg::ST_REFUSED;
            end else begin
               mem_we        = 1'b1;
               stored_in     = stored_ff + CW'(1);
               replaying_in  = (stored_ff + CW'(1)) >= w_eff;
               result.status = pru_pkg::ST_PUSHED;
            end
         end else if (!replaying_ff && stored_ff < w_eff) begin
            result.status = pru_pkg::ST_EMPTY;
         end else begin
            replaying_in = 1'b1;
            if (rpos_ff < w_eff) begin
               result.status = pru_pkg::ST_PIXEL;
               mem_re        = 1'b1;
               if (rep_sum >= {1'b0, s_eff}) begin
                  rep_in    = '0;
                  rpos_next = rpos_ff + CW'(1);
               end else begin
                  rep_in    = rep_sum[pru_pkg::SCALE_W-1:0];
               end
               rpos_in = rpos_next;
               le      = (rpos_next >= w_eff) && (pad_len == 2'd0);
            end else begin
               result.status = pru_pkg::ST_PAD;
               pad_cnt_in    = pad_sum[1:0];
               le            = pad_sum >= {1'b0, pad_len};
            end
            if (le) begin
               rpos_in    = '0;
               rep_in     = '0;
               pad_cnt_in = '0;
               if (replica_sum >= {1'b0, s_eff}) begin
                  result.row_done = 1'b1;
                  replica_in      = '0;
                  stored_in       = '0;
                  replaying_in    = 1'b0;
               end else begin
                  replica_in = replica_sum[pru_pkg::SCALE_W-1:0];
               end
            end
            result.line_end = le;
         end
      end
   end

   assign mem_waddr = stored_ff[AW-1:0];
   assign mem_raddr = rpos_ff[AW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff     <= pru_pkg::SCALE_RESET;
         width_ff     <= pru_pkg::WIDTH_RESET;
         stored_ff    <= '0;
         rpos_ff      <= '0;
         rep_ff       <= '0;
         replica_ff   <= '0;
         pad_cnt_ff   <= '0;
         replaying_ff <= 1'b0;
      end else begin
         scale_ff     <= scale_in;
         width_ff     <= width_in;
         stored_ff    <= stored_in;
         rpos_ff      <= rpos_in;
         rep_ff       <= rep_in;
         replica_ff   <= replica_in;
         pad_cnt_ff   <= pad_cnt_in;
         replaying_ff <= replaying_in;
      end
   end

   `PRU_ASSERT_IMPL(a_no_write_in_replay, clock, reset, mem_we, !replaying_ff)
   `PRU_ASSERT_IMPL(a_single_access, clock, reset, mem_we, !mem_re)
   `PRU_ASSERT_IMPL(a_read_in_row, clock, reset, mem_re, rpos_ff < w_eff)
   `PRU_ASSERT_NEXT(a_row_done_reload, clock, reset, result.row_done, stored_ff == '0 && !replaying_ff)

endmodule

// ===== hdl/pru_out.sv =====
// result pipeline: store read stage plus output register
`timescale 1ns / 1ps

module pru_out (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        accept,
   input  pru_pkg::result_type         result,
   input  logic [pru_pkg::PIX_W-1:0]   rd_data,
   output logic                        in_ready,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [pru_pkg::PIX_W-1:0]   rsp_tdata,
   output logic [pru_pkg::USER_W-1:0]  rsp_tuser,
   output logic                        rsp_tlast
);

   logic                      rd_valid_ff, rd_valid_in;
   pru_pkg::result_type       rd_res_ff;
   logic                      out_valid_ff, out_valid_in;
   pru_pkg::result_type       out_res_ff;
   logic [pru_pkg::PIX_W-1:0] out_pix_ff;
   logic                      out_free;
   logic                      advance;

   assign out_free = !out_valid_ff || rsp_tready;
   assign advance  = rd_valid_ff && out_free;
   // read stage frees up as it moves on, so a new beat enters while one waits
   assign in_ready = !rd_valid_ff || out_free;

   always_comb begin
      rd_valid_in = rd_valid_ff;
      if (accept) begin
         rd_valid_in = 1'b1;
      end else if (advance) begin
         rd_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff  <= rd_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rd_res_ff <= result;
      end
      if (advance) begin
         out_res_ff <= rd_res_ff;
         out_pix_ff <= (rd_res_ff.status == pru_pkg::ST_PIXEL) ? rd_data : '0;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_pix_ff;
   assign rsp_tuser  = {out_res_ff.row_done, out_res_ff.status};
   assign rsp_tlast  = out_res_ff.line_end;

endmodule

// ===== hdl/pixel_replication_upscaler.sv =====
// Integer nearest-neighbor upscaler for 24-bit pixel rows. A beat with
// req_tuser low pushes one source pixel into the line store; once
// source_width pixels are held, each beat with req_tuser high returns one
// output unit (a pixel repeated scale_factor times across the line, then
// zero pad bytes up to a 4-byte line), and the line is replayed
// scale_factor times before loading resumes. Every request beat gives
// exactly one response beat. The block takes one beat per clock while
// rsp_tready keeps up; results pass the read stage and output register.
// A beat makes one store write or read at most. No clearing pass runs
// after reset: only counters and registers are reset. The user writes
// registers through csr_we/csr_index/csr_wdata while the block is idle; not enforced.
`timescale 1ns / 1ps

module pixel_replication_upscaler #(
   parameter int MAX_WIDTH = 1024,
   parameter int MAX_SCALE = 100
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic [0:0]                  csr_index,
   input  logic [pru_pkg::CSR_W-1:0]   csr_wdata,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [pru_pkg::PIX_W-1:0]   req_tdata,   // in_blue, in_green, in_red
   input  logic [0:0]                  req_tuser,   // cmd
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [pru_pkg::PIX_W-1:0]   rsp_tdata,   // out_blue, out_green, out_red
   output logic [pru_pkg::USER_W-1:0]  rsp_tuser,   // status[2:0], row_done
   output logic                        rsp_tlast    // line_end
);

   localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int CW = ($clog2(MAX_WIDTH + 1) > 2) ? $clog2(MAX_WIDTH + 1) : 2;

   logic                      accept;
   logic                      mem_we;
   logic [AW-1:0]             mem_waddr;
   logic                      mem_re;
   logic [AW-1:0]             mem_raddr;
   logic [pru_pkg::PIX_W-1:0] rd_data;
   pru_pkg::result_type       result;

   assign accept = req_tvalid && req_tready;

   pru_ctrl #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_SCALE (MAX_SCALE),
      .CW        (CW),
      .AW        (AW)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .accept    (accept),
      .cmd       (pru_pkg::cmd_type'(req_tuser)),
      .mem_we    (mem_we),
      .mem_waddr (mem_waddr),
      .mem_re    (mem_re),
      .mem_raddr (mem_raddr),
      .result    (result)
   );

   // a read in the cycle after a write to the same entry sees the new data
   pru_line_store #(
      .DEPTH (MAX_WIDTH),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (req_tdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (rd_data)
   );

   pru_out u_out (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .result     (result),
      .rd_data    (rd_data),
      .in_ready   (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== sim/tb.sv =====
// self-checking testbench for the pixel replication upscaler
`timescale 1ns / 1ps

module tb;

   localparam int MAX_WIDTH   = 1024;
   localparam int MAX_SCALE   = 100;
   localparam int ITEM_TARGET = 1500;
   localparam int CYCLE_LIMIT = 400000;
   // upper bound on the beats one row may take, pushes included
   localparam int ROW_CAP     = 250;

   typedef struct packed {
      pru_pkg::cmd_type          cmd;
      logic [pru_pkg::PIX_W-1:0] pix;
   } request_type;

   typedef struct packed {
      pru_pkg::status_type       status;
      logic [pru_pkg::PIX_W-1:0] pix;
      logic                      line_end;
      logic                      row_done;
   } unit_type;

   logic                        clock      = 1'b0;
   logic                        reset      = 1'b1;
   logic                        csr_we     = 1'b0;
   logic [0:0]                  csr_index  = 1'b0;
   logic [pru_pkg::CSR_W-1:0]   csr_wdata  = '0;
   logic                        req_tvalid = 1'b0;
   logic                        req_tready;
   logic [pru_pkg::PIX_W-1:0]   req_tdata  = '0;
   logic [0:0]                  req_tuser  = 1'b0;
   logic                        rsp_tvalid;
   logic                        rsp_tready = 1'b0;
   logic [pru_pkg::PIX_W-1:0]   rsp_tdata;
   logic [pru_pkg::USER_W-1:0]  rsp_tuser;
   logic                        rsp_tlast;

   pixel_replication_upscaler u_top (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // upscaler state as the testbench sees it
   logic [pru_pkg::SCALE_W-1:0] scale_reg = pru_pkg::SCALE_RESET;
   logic [pru_pkg::WIDTH_W-1:0] width_reg = pru_pkg::WIDTH_RESET;
   logic [pru_pkg::PIX_W-1:0]   row_store [MAX_WIDTH];
   int                          stored     = 0;
   int                          column     = 0;
   int                          copies     = 0;
   int                          lines_done = 0;
   int                          pads_sent  = 0;
   int                          store_high = 0;
   bit                          replaying  = 1'b0;

   request_type pending_reqs[$];
   unit_type    expected_units[$];
   request_type cur_req;
   int          send_idle_pct = 30;
   int          take_idle_pct = 55;
   int          items_sent    = 0;
   int          results_seen  = 0;
   int          rows_done     = 0;
   int          errors        = 0;
   int          cycle_count   = 0;

   function automatic int scale_now();
      int s;
      s = scale_reg;
      if (s == 0) s = 1;
      if (s > MAX_SCALE) s = MAX_SCALE;
      return s;
   endfunction

   function automatic int width_now();
      int w;
      w = width_reg;
      if (w == 0) w = 1;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      return w;
   endfunction

   function automatic int pad_now();
      return (4 - (width_now() * 3 * scale_now()) % 4) % 4;
   endfunction

   // beats of one whole row for given register codes, worst-case padding
   function automatic int row_cost(int w_code, int s_code);
      int w, s;
      w = (w_code == 0) ? 1 : ((w_code > MAX_WIDTH) ? MAX_WIDTH : w_code);
      s = (s_code == 0) ? 1 : ((s_code > MAX_SCALE) ? MAX_SCALE : s_code);
      return w + s * (w * s + 3);
   endfunction

   function automatic int fit_width(int w_code);
      int w;
      w = w_code;
      while (w > 1 && row_cost(w, int'(scale_reg)) > ROW_CAP) w--;
      return w;
   endfunction

   function automatic int fit_scale(int s_code);
      int s;
      s = s_code;
      while (s > 1 && row_cost(int'(width_reg), s) > ROW_CAP) s--;
      return s;
   endfunction

   function automatic unit_type upscale_predict(request_type r);
      unit_type u;
      int       w, s, pad;
      w = width_now();
      s = scale_now();
      pad = pad_now();
      u.status = pru_pkg::ST_EMPTY;
      u.pix = '0;
      u.line_end = 1'b0;
      u.row_done = 1'b0;
      if (r.cmd == pru_pkg::CMD_PUSH) begin
         if (replaying || stored >= w) begin
            replaying = 1'b1;
            u.status = pru_pkg::ST_REFUSED;
         end else begin
            row_store[stored] = r.pix;
            stored++;
            if (stored > store_high) store_high = stored;
            if (stored >= w) replaying = 1'b1;
            u.status = pru_pkg::ST_PUSHED;
         end
         return u;
      end
      if (!replaying) begin
         if (stored < w) return u;
         replaying = 1'b1;
      end
      if (column < w) begin
         u.status = pru_pkg::ST_PIXEL;
         u.pix = row_store[column];
         copies++;
         if (copies >= s) begin
            copies = 0;
            column++;
         end
         u.line_end = (column >= w && pad == 0);
      end else begin
         u.status = pru_pkg::ST_PAD;
         pads_sent++;
         u.line_end = (pads_sent >= pad);
      end
      if (u.line_end) begin
         column = 0;
         copies = 0;
         pads_sent = 0;
         lines_done++;
         if (lines_done >= s) begin
            u.row_done = 1'b1;
            lines_done = 0;
            stored = 0;
            replaying = 1'b0;
         end
      end
      return u;
   endfunction

   // pulls still owed before the block goes back to loading
   function automatic int pulls_to_row_end();
      int w, s, pad, line_units, left;
      w = width_now();
      s = scale_now();
      pad = pad_now();
      line_units = w * s + pad;
      if (!replaying) return s * line_units;
      if (column < w) begin
         left = ((s - copies > 1) ? s - copies : 1) + (w - column - 1) * s + pad;
      end else begin
         left = (pad - pads_sent > 1) ? pad - pads_sent : 1;
      end
      if (s - lines_done - 1 > 0) left += (s - lines_done - 1) * line_units;
      return left;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      errors++;
      $display("mismatch on response %0d: %s got %0h expected %0h",
               results_seen, what, got, want);
   endtask

   task automatic send_item(pru_pkg::cmd_type cmd, logic [pru_pkg::PIX_W-1:0] pix);
      request_type r;
      r.cmd = cmd;
      r.pix = pix;
      pending_reqs.push_back(r);
      items_sent++;
   endtask

   task automatic wait_drained();
      while (results_seen < items_sent) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(pru_pkg::csr_index_type idx, int value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= pru_pkg::CSR_W'(value);
      if (idx == pru_pkg::CSR_SCALE) scale_reg = pru_pkg::SCALE_W'(value);
      else width_reg = pru_pkg::WIDTH_W'(value);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // load and replay up to the end of a row; from_start assumes a row
   // boundary, otherwise the current (drained) state is used
   task automatic run_row(bit from_start, int noise_pct);
      int need, pulls;
      need = from_start ? width_now() : width_now() - stored;
      if (from_start || !replaying) begin
         for (int i = 0; i < need; i++) begin
            if ($urandom_range(0, 99) < noise_pct)
               send_item(pru_pkg::CMD_PULL, pru_pkg::PIX_W'($urandom));
            send_item(pru_pkg::CMD_PUSH, pru_pkg::PIX_W'($urandom));
         end
         pulls = scale_now() * (width_now() * scale_now() + pad_now());
      end else begin
         pulls = pulls_to_row_end();
      end
      for (int i = 0; i < pulls; i++) begin
         if ($urandom_range(0, 99) < noise_pct)
            send_item(pru_pkg::CMD_PUSH, pru_pkg::PIX_W'($urandom));
         send_item(pru_pkg::CMD_PULL, pru_pkg::PIX_W'($urandom));
      end
   endtask

   // cut a row short, change a register in mid-row, then finish it
   task automatic break_row(int noise_pct);
      int w, s, k, j, top;
      w = width_now();
      s = scale_now();
      if ($urandom_range(0, 1)) begin
         k = $urandom_range(0, w - 1);
         repeat (k) send_item(pru_pkg::CMD_PUSH, pru_pkg::PIX_W'($urandom));
         wait_drained();
         if ($urandom_range(0, 1)) write_csr(pru_pkg::CSR_WIDTH, stored);
         else write_csr(pru_pkg::CSR_WIDTH, fit_width($urandom_range(0, 40)));
      end else begin
         repeat (w) send_item(pru_pkg::CMD_PUSH, pru_pkg::PIX_W'($urandom));
         j = s * (w * s + pad_now());
         j = $urandom_range(1, (j < 300) ? j : 300);
         repeat (j) send_item(pru_pkg::CMD_PULL, pru_pkg::PIX_W'($urandom));
         wait_drained();
         // never raise the width past what the store has ever held
         top = (store_high < 40) ? store_high : 40;
         case ($urandom_range(0, 2))
            0: begin
               write_csr(pru_pkg::CSR_SCALE, fit_scale($urandom_range(0, 8)));
            end
            1: begin
               write_csr(pru_pkg::CSR_WIDTH, fit_width($urandom_range(0, top)));
            end
            default: begin
               write_csr(pru_pkg::CSR_SCALE, fit_scale($urandom_range(0, 8)));
               write_csr(pru_pkg::CSR_WIDTH, fit_width($urandom_range(0, top)));
            end
         endcase
      end
      wait_drained();
      run_row(1'b0, noise_pct);
   endtask

   function automatic int pick_scale();
      case ($urandom_range(0, 9))
         0: return 0;
         1: return 1;
         2: return $urandom_range(6, 9);
         default: return $urandom_range(1, 5);
      endcase
   endfunction

   function automatic int pick_width();
      case ($urandom_range(0, 9))
         0: return 0;
         1: return $urandom_range(25, 80);
         default: return $urandom_range(1, 24);
      endcase
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) expected_units.push_back(upscale_predict(cur_req));
         if (!req_tvalid || req_tready) begin
            if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               cur_req = pending_reqs.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= cur_req.pix;
               req_tuser <= cur_req.cmd;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // response side backpressure
   always @(posedge clock) begin
      rsp_tready <= !reset && ($urandom_range(0, 99) >= take_idle_pct);
   end

   // response monitor
   always @(posedge clock) begin
      unit_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (expected_units.size() == 0) begin
            report_mismatch("unexpected beat, tuser", rsp_tuser, 0);
         end else begin
            want = expected_units.pop_front();
            if (rsp_tuser[2:0] !== want.status)
               report_mismatch("status", rsp_tuser[2:0], want.status);
            if (rsp_tdata !== want.pix)
               report_mismatch("pixel", rsp_tdata, want.pix);
            if (rsp_tlast !== want.line_end)
               report_mismatch("line_end", rsp_tlast, want.line_end);
            if (rsp_tuser[3] !== want.row_done)
               report_mismatch("row_done", rsp_tuser[3], want.row_done);
            if (want.row_done) rows_done++;
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles with %0d responses outstanding",
               cycle_count, items_sent - results_seen);
      $display("Verification failed");
      $finish;
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // reset values: one pixel per row, no scaling
      send_item(pru_pkg::CMD_PULL, '1);
      send_item(pru_pkg::CMD_PUSH, '0);
      send_item(pru_pkg::CMD_PUSH, '1);
      send_item(pru_pkg::CMD_PULL, '0);
      send_item(pru_pkg::CMD_PULL, '0);
      send_item(pru_pkg::CMD_PUSH, '1);
      send_item(pru_pkg::CMD_PULL, '1);
      send_item(pru_pkg::CMD_PULL, '1);
      wait_drained();

      // zero in either register acts as one
      write_csr(pru_pkg::CSR_SCALE, 0);
      write_csr(pru_pkg::CSR_WIDTH, 0);
      run_row(1'b1, 0);
      wait_drained();

      // width lowered onto the stored count, then a pull starts replay
      write_csr(pru_pkg::CSR_SCALE, 1);
      write_csr(pru_pkg::CSR_WIDTH, 3);
      send_item(pru_pkg::CMD_PUSH, 24'hA5C35A);
      send_item(pru_pkg::CMD_PUSH, 24'h5A3CA5);
      wait_drained();
      write_csr(pru_pkg::CSR_WIDTH, 2);
      run_row(1'b0, 0);
      wait_drained();

      // same, but a refused push starts replay
      write_csr(pru_pkg::CSR_WIDTH, 3);
      send_item(pru_pkg::CMD_PUSH, 24'h0F0F0F);
      send_item(pru_pkg::CMD_PUSH, 24'hF0F0F0);
      wait_drained();
      write_csr(pru_pkg::CSR_WIDTH, 2);
      send_item(pru_pkg::CMD_PUSH, '1);
      wait_drained();
      run_row(1'b0, 0);
      wait_drained();

      // pixels done, scale raised so no pad is owed: a pad closes the line
      send_item(pru_pkg::CMD_PUSH, 24'h123456);
      send_item(pru_pkg::CMD_PUSH, 24'h654321);
      send_item(pru_pkg::CMD_PULL, '0);
      send_item(pru_pkg::CMD_PULL, '0);
      wait_drained();
      write_csr(pru_pkg::CSR_SCALE, 2);
      run_row(1'b0, 0);
      wait_drained();

      // top scale codes, cut short and lowered mid-line
      write_csr(pru_pkg::CSR_WIDTH, 1);
      write_csr(pru_pkg::CSR_SCALE, 100);
      send_item(pru_pkg::CMD_PUSH, 24'hC0FFEE);
      repeat (110) send_item(pru_pkg::CMD_PULL, pru_pkg::PIX_W'($urandom));
      wait_drained();
      write_csr(pru_pkg::CSR_SCALE, 127);
      repeat (20) send_item(pru_pkg::CMD_PULL, pru_pkg::PIX_W'($urandom));
      wait_drained();
      write_csr(pru_pkg::CSR_SCALE, 1);
      run_row(1'b0, 0);
      wait_drained();

      // width codes past the store size while loading
      write_csr(pru_pkg::CSR_WIDTH, 2047);
      repeat (5) send_item(pru_pkg::CMD_PUSH, pru_pkg::PIX_W'($urandom));
      wait_drained();
      write_csr(pru_pkg::CSR_WIDTH, 1024);
      write_csr(pru_pkg::CSR_WIDTH, 5);
      run_row(1'b0, 0);
      wait_drained();

      while (items_sent < ITEM_TARGET) begin
         if (items_sent < ITEM_TARGET / 3) begin
            send_idle_pct = 30;
            take_idle_pct = 55;
         end else if (items_sent < 2 * ITEM_TARGET / 3) begin
            send_idle_pct = 55;
            take_idle_pct = 30;
         end else begin
            send_idle_pct = 0;
            take_idle_pct = 0;
         end
         write_csr(pru_pkg::CSR_SCALE, pick_scale());
         write_csr(pru_pkg::CSR_WIDTH, fit_width(pick_width()));
         if ($urandom_range(0, 99) < 65) begin
            repeat ($urandom_range(1, 3)) run_row(1'b1, $urandom_range(0, 8));
         end else begin
            break_row($urandom_range(0, 8));
         end
         wait_drained();
      end
      repeat (20) @(posedge clock);

      if (expected_units.size() != 0)
         report_mismatch("responses never returned", expected_units.size(), 0);
      $display("upscaler run: %0d requests, %0d responses checked, %0d rows replayed",
               items_sent, results_seen, rows_done);
      $display("scale codes 0..127, widths 0..2047, mid-row register changes, %0d mismatches",
               errors);
      if (errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
